// ----- design/tkss_pkg.sv -----
// ----------------------------------------------------------------------------
// tkss_pkg
// Shared types for the time keyed selection sorter: input and result words,
// the stored record layout and the scan control group.
// ----------------------------------------------------------------------------
package tkss_pkg;

  // Input word, one key event plus end-of-set flag
  typedef struct packed {
    logic [31:0] event_time;
    logic [7:0]  key_code;
    logic        press;
    logic        last_in;
  } in_word_t;

  // Result word, one sorted record
  typedef struct packed {
    logic [31:0] sorted_time;
    logic [7:0]  sorted_code;
    logic        sorted_press;
    logic        last_out;
    logic        overflow;
  } out_word_t;

  // Stored record, 41 bits
  typedef struct packed {
    logic [31:0] rtime;
    logic [7:0]  code;
    logic        press;
  } rec_t;

  // Control that travels with a read word from the record memory
  typedef struct packed {
    logic vld;    // read data valid this cycle
    logic first;  // word is the record at the current position
    logic last;   // word is the final record of the scan
  } scan_ctl_t;

endpackage

// ----- design/tkss_mem.sv -----
// ----------------------------------------------------------------------------
// tkss_mem
// Record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tkss_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  tkss_pkg::rec_t    wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output tkss_pkg::rec_t    rdata
);

  tkss_pkg::rec_t mem [DEPTH];
  tkss_pkg::rec_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/tkss_scan.sv -----
// ----------------------------------------------------------------------------
// tkss_scan
// Minimum tracker: follows the read words of one scan and keeps the first
// record with the strictly smallest time, its address, and the record that
// sat at the scan's starting position.
// ----------------------------------------------------------------------------
module tkss_scan #(
  parameter int AW = 6
) (
  input  logic                clk,
  input  tkss_pkg::scan_ctl_t ctl,
  input  logic [AW-1:0]       idx,
  input  tkss_pkg::rec_t      rdata,
  output tkss_pkg::rec_t      best,
  output logic [AW-1:0]       best_idx,
  output tkss_pkg::rec_t      hold
);

  tkss_pkg::rec_t  best_r;
  logic [AW-1:0]   best_idx_r;
  tkss_pkg::rec_t  hold_r;
  logic            take;

  // first word seeds the minimum; later words replace it only when smaller
  assign take = ctl.vld && (ctl.first || (rdata.rtime < best_r.rtime));

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= rdata;
      best_idx_r <= idx;
    end
    if (ctl.vld && ctl.first) begin
      hold_r <= rdata;
    end
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;
  assign hold     = hold_r;

endmodule

// ----- design/time_keyed_selection_sorter_top.sv -----
// ----------------------------------------------------------------------------
// time_keyed_selection_sorter_top
// Collects key event records, sorts them by time with a selection sort and
// emits them in order.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle while busy is low; a word that finds the
// store full is dropped and marks overflow on every result of its set. The
// word with last_in ends the set and busy rises. For sorted position i of n
// records the block reads records i..n-1 through the single read port of the
// record memory, one per cycle, then emits the smallest one and writes the
// displaced record back. Results come one per strobe on out_valid and cannot
// be held off; busy drops after the result marked last_out.
// ----------------------------------------------------------------------------
module time_keyed_selection_sorter_top #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tkss_pkg::in_word_t    in_word,
  output logic                  out_valid,
  output tkss_pkg::out_word_t   out_word
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          issuing_r, issuing_nxt;

  tkss_pkg::scan_ctl_t ctl_r, ctl_nxt;
  logic [AW-1:0]       rd_idx_r;

  logic              accept;
  logic              room;
  logic [CW-1:0]     cnt_new;
  logic              rd_at_end;
  logic              pos_at_end;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  tkss_pkg::rec_t    mem_wdata;
  logic              mem_re;
  tkss_pkg::rec_t    mem_rdata;

  tkss_pkg::rec_t    best;
  logic [AW-1:0]     best_idx;
  tkss_pkg::rec_t    hold;

  // handshake and load bookkeeping
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign room       = (count_r < CW'(STORE_DEPTH));
  assign cnt_new    = room ? (count_r + CW'(1)) : count_r;
  assign rd_at_end  = (CW'(rd_addr_r) == (n_r - CW'(1)));
  assign pos_at_end = ((CW'(pos_r) + CW'(1)) == n_r);

  // memory port selection: load writes in idle, swap write in finish
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = '{rtime: in_word.event_time, code: in_word.key_code,
                  press: in_word.press};
    if (state_r == ST_FINISH) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx;
      mem_wdata = hold;
    end else if (accept && room) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_r == ST_SCAN) && issuing_r;

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    drop_nxt    = drop_r;
    n_nxt       = n_r;
    pos_nxt     = pos_r;
    rd_addr_nxt = rd_addr_r;
    issuing_nxt = issuing_r;
    ctl_nxt     = '{vld: mem_re, first: (rd_addr_r == pos_r), last: rd_at_end};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = cnt_new;
          drop_nxt  = drop_r | !room;
          if (in_word.last_in) begin
            n_nxt       = cnt_new;
            pos_nxt     = '0;
            rd_addr_nxt = '0;
            issuing_nxt = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issuing_r) begin
          if (rd_at_end) begin
            issuing_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + AW'(1);
          end
        end
        if (ctl_r.vld && ctl_r.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (pos_at_end) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt     = pos_r + AW'(1);
          rd_addr_nxt = pos_r + AW'(1);
          issuing_nxt = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      drop_r    <= 1'b0;
      issuing_r <= 1'b0;
      ctl_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      drop_r    <= drop_nxt;
      issuing_r <= issuing_nxt;
      ctl_r     <= ctl_nxt;
    end
  end

  // position and address registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    pos_r     <= pos_nxt;
    rd_addr_r <= rd_addr_nxt;
    rd_idx_r  <= rd_addr_r;
  end

  tkss_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  tkss_scan #(
    .AW (AW)
  ) u_scan (
    .clk      (clk),
    .ctl      (ctl_r),
    .idx      (rd_idx_r),
    .rdata    (mem_rdata),
    .best     (best),
    .best_idx (best_idx),
    .hold     (hold)
  );

  // result word
  assign out_valid = (state_r == ST_FINISH);
  assign out_word  = '{sorted_time: best.rtime, sorted_code: best.code,
                       sorted_press: best.press, last_out: pos_at_end,
                       overflow: drop_r};

  // read data only arrives during a scan
  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.vld |-> (state_r == ST_SCAN))
    else $error("read data outside scan");

  // the swap write never meets a read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write overlap");

  // result strobes never come back to back
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  // store count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STORE_DEPTH))
    else $error("record count beyond depth");

  // the final result leaves the block idle and empty
  a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_out) |=> (!busy && (count_r == '0) && !drop_r))
    else $error("set not closed after last result");

endmodule

// ----- sim/sorted_record_checker.sv -----
// ----------------------------------------------------------------------------
// sorted_record_checker
// Watches the input and result channels of the time keyed selection sorter,
// keeps its own copy of the record store, works out the sorted records of
// each set when the last word of the set is taken, and checks every result
// word field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module sorted_record_checker #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  tkss_pkg::in_word_t   in_word,
  input  logic                 out_valid,
  input  tkss_pkg::out_word_t  out_word,
  output int                   mismatch_count,
  output int                   pending_results
);

  tkss_pkg::rec_t      set_store [STORE_DEPTH];
  int                  set_count;
  bit                  set_dropped;
  tkss_pkg::out_word_t sorted_due [$];
  int                  result_index;

  // One line per mismatch, and count it
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t, result %0d: %s", $time, result_index, what);
    mismatch_count++;
  endtask

  // Store or drop one word; on the last word sort the set and queue its records
  task automatic absorb_word(input tkss_pkg::in_word_t w);
    int                  n;
    int                  best;
    tkss_pkg::rec_t      hold;
    tkss_pkg::out_word_t exp_word;
    if (set_count < STORE_DEPTH) begin
      set_store[set_count] = '{rtime: w.event_time, code: w.key_code, press: w.press};
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!w.last_in) return;
    n = set_count;
    // selection sort: first strictly smallest time wins, then swap into place
    for (int i = 0; i + 1 < n; i++) begin
      best = i;
      for (int j = i + 1; j < n; j++)
        if (set_store[j].rtime < set_store[best].rtime) best = j;
      hold            = set_store[i];
      set_store[i]    = set_store[best];
      set_store[best] = hold;
    end
    for (int k = 0; k < n; k++) begin
      exp_word.sorted_time  = set_store[k].rtime;
      exp_word.sorted_code  = set_store[k].code;
      exp_word.sorted_press = set_store[k].press;
      exp_word.last_out     = (k + 1 == n);
      exp_word.overflow     = set_dropped;
      sorted_due.push_back(exp_word);
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endtask

  // Results are checked before the input word of the same edge is taken
  always @(posedge clk) begin
    tkss_pkg::out_word_t exp_word;
    if (!rst_n) begin
      set_count      = 0;
      set_dropped    = 1'b0;
      mismatch_count = 0;
      result_index   = 0;
      sorted_due.delete();
    end else begin
      if (out_valid) begin
        if (sorted_due.size() == 0) begin
          report_mismatch($sformatf("unexpected record, time %h code %h",
                                    out_word.sorted_time, out_word.sorted_code));
        end else begin
          exp_word = sorted_due.pop_front();
          if (out_word.sorted_time !== exp_word.sorted_time)
            report_mismatch($sformatf("sorted_time %h, expected %h",
                                      out_word.sorted_time, exp_word.sorted_time));
          if (out_word.sorted_code !== exp_word.sorted_code)
            report_mismatch($sformatf("sorted_code %h, expected %h",
                                      out_word.sorted_code, exp_word.sorted_code));
          if (out_word.sorted_press !== exp_word.sorted_press)
            report_mismatch($sformatf("sorted_press %b, expected %b",
                                      out_word.sorted_press, exp_word.sorted_press));
          if (out_word.last_out !== exp_word.last_out)
            report_mismatch($sformatf("last_out %b, expected %b",
                                      out_word.last_out, exp_word.last_out));
          if (out_word.overflow !== exp_word.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      out_word.overflow, exp_word.overflow));
        end
        result_index++;
      end
      if (start && !busy) absorb_word(in_word);
    end
    pending_results <= sorted_due.size();
  end

endmodule

// ----- sim/time_keyed_selection_sorter_top_tb.sv -----
// ----------------------------------------------------------------------------
// time_keyed_selection_sorter_top_tb
// Drives sets of key event words into the sorter: a short directed part with
// lone records, extreme times, equal times and ordered runs, then random sets,
// mostly small, a few filling or overflowing the store. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module time_keyed_selection_sorter_top_tb;

  localparam int DEPTH       = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int WORD_TARGET = 240;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  tkss_pkg::in_word_t  in_word;
  logic                out_valid;
  tkss_pkg::out_word_t out_word;

  int mismatch_count;
  int pending_results;
  int words_sent   = 0;
  int stall_cycles = 0;
  bit idle_off     = 1'b0;

  always #1 clk = ~clk;

  time_keyed_selection_sorter_top #(.STORE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  sorted_record_checker #(.STORE_DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_word        (out_word),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Watchdog: too long with no word taken and no result seen
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Random sort key: small values to force ties, full range, and both extremes
  function automatic logic [31:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      return $urandom_range(0, 7);
    else if (r < 80) return $urandom;
    else if (r < 90) return 32'h0;
    else             return 32'hFFFF_FFFF;
  endfunction

  function automatic tkss_pkg::in_word_t make_word(input logic [31:0] t, input bit last);
    tkss_pkg::in_word_t w;
    w.event_time = t;
    w.key_code   = 8'($urandom_range(0, 255));
    w.press      = 1'($urandom_range(0, 1));
    w.last_in    = last;
    return w;
  endfunction

  // Offer one word, with an occasional gap of noise first; returns once taken
  task automatic send_word(input tkss_pkg::in_word_t w);
    int gap;
    if (!idle_off && $urandom_range(0, 99) < 3) begin
      gap = $urandom_range(1, 4);
      start   <= 1'b0;
      in_word <= make_word($urandom, 1'($urandom_range(0, 1)));
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_random_set(input int n);
    for (int k = 0; k < n; k++) begin
      idle_off = (words_sent >= 150 && words_sent < 230);
      send_word(make_word(pick_time(), k == n - 1));
    end
  endtask

  initial begin
    logic [31:0] tie_times [5];
    int          set_len;
    tie_times = '{32'd3, 32'd1, 32'd3, 32'd1, 32'd2};
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // lone record with all-ones fields
    send_word(tkss_pkg::in_word_t'{32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1});
    // two records in reverse order at the extreme times
    send_word(tkss_pkg::in_word_t'{32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0});
    send_word(tkss_pkg::in_word_t'{32'h0000_0000, 8'hFF, 1'b1, 1'b1});
    // all times equal: the strict comparison keeps the codes in input order
    for (int k = 0; k < 5; k++)
      send_word(tkss_pkg::in_word_t'{32'd5, 8'(k), k[0], k == 4});
    // repeated times mixed with distinct ones
    for (int k = 0; k < 5; k++)
      send_word(tkss_pkg::in_word_t'{tie_times[k], 8'(8'h10 + k), ~k[0], k == 4});
    // descending run, then ascending run
    for (int k = 0; k < 4; k++)
      send_word(tkss_pkg::in_word_t'{32'(1000 - k * 100), 8'(8'h80 + k), 1'b1, k == 3});
    for (int k = 0; k < 4; k++)
      send_word(tkss_pkg::in_word_t'{32'(k * 7), 8'(8'hC0 + k), 1'b0, k == 3});

    // exactly full store, then a set that drops its tail including last_in
    send_random_set(DEPTH);
    send_random_set(DEPTH + 2);
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 99) < 5) set_len = $urandom_range(DEPTH - 4, DEPTH + 6);
      else                           set_len = $urandom_range(1, 12);
      send_random_set(set_len);
    end

    // drain: every expected record out, block idle, then a short grace period
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
